FILE: rtl/ppcf_pkg.sv
// Package for the pixel point color filter.
// Holds field widths, register indexes and filter mode codes; no dependencies.
`timescale 1ns / 1ps

package ppcf_pkg;

  localparam int unsigned MaxDimDef = 4096;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MODE_W    = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_COPY      = 3'd0,
    MODE_VIGNETTE  = 3'd1,
    MODE_CLARENDON = 3'd2,
    MODE_GRAY      = 3'd3,
    MODE_CONTRAST  = 3'd4,
    MODE_LIGHTEN   = 3'd5,
    MODE_DARKEN    = 3'd6,
    MODE_QUANTIZE  = 3'd7
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

endpackage

FILE: rtl/ppcf_in_if.sv
// Input pixel channel: valid/ready handshake with color and position payload.
// Depends on ppcf_pkg for field widths.
`timescale 1ns / 1ps

interface ppcf_in_if;
  logic                         valid;
  logic                         ready;
  logic [ppcf_pkg::CH_W-1:0]    in_red;
  logic [ppcf_pkg::CH_W-1:0]    in_green;
  logic [ppcf_pkg::CH_W-1:0]    in_blue;
  logic [ppcf_pkg::POS_W-1:0]   pixel_row;
  logic [ppcf_pkg::POS_W-1:0]   pixel_col;

  modport source (output valid, in_red, in_green, in_blue, pixel_row, pixel_col,
                  input ready);
  modport sink   (input valid, in_red, in_green, in_blue, pixel_row, pixel_col,
                  output ready);
endinterface

FILE: rtl/ppcf_out_if.sv
// Output pixel channel: valid/ready handshake with filtered color payload.
// Depends on ppcf_pkg for field widths.
`timescale 1ns / 1ps

interface ppcf_out_if;
  logic                      valid;
  logic                      ready;
  logic [ppcf_pkg::CH_W-1:0] out_red;
  logic [ppcf_pkg::CH_W-1:0] out_green;
  logic [ppcf_pkg::CH_W-1:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

FILE: rtl/pixel_point_color_filter_top.sv
// Pixel point color filter, top level.
// Depends on ppcf_pkg, ppcf_in_if, ppcf_out_if, ppcf_sqrt_pipe, ppcf_div_pipe.
`timescale 1ns / 1ps
//
// Usage:
//   pix_i carries one RGB pixel with its row and column per transfer; pix_o
//   returns one filtered pixel per transfer, in order. Write filter_mode,
//   image_width and image_height through cfg_we_i/cfg_idx_i/cfg_wdata_i only
//   while no pixel is in flight.
// Latency and throughput:
//   Every pixel passes through the same register stages to the output
//   register, whatever the mode; one pixel enters per cycle unless the
//   pipeline stalls. The depth is set by the vignette path: 21 stages of the
//   square root (one root bit each) and 8 stages of the divider (one quotient
//   bit each), plus input, square, scale, multiply and output stages.
// Reset:
//   rst_ni clears all valid bits and loads mode copy, width 1, height 1.
// Stall:
//   The whole pipeline holds while the output register is full and the sink
//   is not ready; pix_i.ready drops in the same cycle, so nothing is dropped.

module pixel_point_color_filter_top #(
  parameter int unsigned MAX_DIM = ppcf_pkg::MaxDimDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ppcf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ppcf_pkg::CFG_W-1:0]      cfg_wdata_i,
  ppcf_in_if.sink                         pix_i,
  ppcf_out_if.source                      pix_o
);

  import ppcf_pkg::*;

  localparam int unsigned W_CAP  = (MAX_DIM < 8191) ? MAX_DIM : 8191;
  localparam int unsigned WC_W   = $clog2(W_CAP + 1);
  localparam int unsigned FULL_W = WC_W + 8;
  localparam int unsigned NUM_W  = FULL_W + CH_W;
  localparam int unsigned D_W    = POS_W + 1;
  localparam int unsigned D2_W   = 2 * D_W;
  localparam int unsigned RAD_W  = D2_W + 16;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned CMP_W  = (FULL_W > ROOT_W) ? FULL_W : ROOT_W;

  // stage indexes
  localparam int unsigned ST_B   = 1;
  localparam int unsigned ST_C   = ST_B + ROOT_W + 1;
  localparam int unsigned ST_D   = ST_C + 1;
  localparam int unsigned ST_DV  = ST_D + CH_W;
  localparam int unsigned ST_OUT = ST_DV + 1;
  localparam int unsigned NST    = ST_OUT + 1;

  typedef struct packed {
    logic            vig;
    logic            zero;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic [3*CH_W-1:0] po;
  } side_t;

  // ---------------------------------------------------------------- config
  mode_e              mode_q;
  logic [CFG_W-1:0]   width_q;
  logic [CFG_W-1:0]   height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_COPY;
      width_q  <= CFG_W'(1);
      height_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:   mode_q   <= mode_e'(cfg_wdata_i[MODE_W-1:0]);
        CFG_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamp image size to MAX_DIM
  logic [WC_W-1:0]  w_cl;
  logic [WC_W-1:0]  h_cl;
  logic [POS_W-1:0] w_half;
  logic [POS_W-1:0] h_half;
  logic [FULL_W-1:0] full;

  assign w_cl   = (32'(width_q) > MAX_DIM)  ? WC_W'(MAX_DIM) : WC_W'(width_q);
  assign h_cl   = (32'(height_q) > MAX_DIM) ? WC_W'(MAX_DIM) : WC_W'(height_q);
  assign w_half = POS_W'(w_cl >> 1);
  assign h_half = POS_W'(h_cl >> 1);
  assign full   = {w_cl, 8'h00};

  // ------------------------------------------------------------ point ops
  function automatic logic [CH_W-1:0] div10(input logic [11:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd3277;
    return p[22:15];
  endfunction

  function automatic logic [3*CH_W-1:0] point_op(input mode_e m,
                                                  input logic [CH_W-1:0] r,
                                                  input logic [CH_W-1:0] g,
                                                  input logic [CH_W-1:0] b);
    logic [9:0]      sum;
    logic [19:0]     prod;
    logic [CH_W-1:0] avg;
    logic [CH_W-1:0] c [3];
    logic [CH_W-1:0] o [3];
    logic [CH_W-1:0] k;
    sum  = 10'(r) + 10'(g) + 10'(b);
    prod = 20'(sum) * 20'd683;
    avg  = prod[18:11];
    c[0] = r;
    c[1] = g;
    c[2] = b;
    for (int i = 0; i < 3; i++) begin
      k = 8'd255 - c[i];
      case (m)
        MODE_CLARENDON: begin
          if (avg >= 8'd170) o[i] = 8'd255 - div10(12'(k) * 12'd3 + 12'd9);
          else if (avg < 8'd90) o[i] = div10(12'(c[i]) * 12'd3);
          else o[i] = c[i];
        end
        MODE_GRAY:     o[i] = avg;
        MODE_CONTRAST: o[i] = (avg >= 8'd127) ? 8'd255 : 8'd0;
        MODE_LIGHTEN:  o[i] = 8'd255 - div10(12'(k) * 12'd8 + 12'd9);
        MODE_DARKEN:   o[i] = div10(12'(c[i]) * 12'd8);
        MODE_QUANTIZE: begin
          if (sum >= 10'd550) o[i] = 8'd255;
          else if (sum <= 10'd150) o[i] = 8'd0;
          else if (r >= g && r >= b) o[i] = (i == 0) ? 8'd255 : 8'd0;
          else if (g >= b) o[i] = (i == 1) ? 8'd255 : 8'd0;
          else o[i] = (i == 2) ? 8'd255 : 8'd0;
        end
        default: o[i] = c[i];
      endcase
    end
    return {o[0], o[1], o[2]};
  endfunction

  // -------------------------------------------------------------- control
  logic           adv;
  logic [NST-1:0] vld_q;

  // advance everything when the output register is empty or being taken
  assign adv         = !vld_q[NST-1] || pix_o.ready;
  assign pix_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], pix_i.valid};
    end
  end

  // --------------------------------------------------------- data path
  side_t              side_in;
  side_t              side_c;
  side_t              side_q [ST_OUT];
  logic signed [D_W-1:0] dx_q;
  logic signed [D_W-1:0] dy_q;
  logic [D2_W-1:0]    d2_q;
  logic [ROOT_W-1:0]  root;
  logic [FULL_W-1:0]  n_q;
  logic [NUM_W-1:0]   prod_q [3];
  logic [CH_W-1:0]    quo [3];
  logic [3*CH_W-1:0]  out_q;
  logic               zero;

  assign side_in.vig  = (mode_q == MODE_VIGNETTE);
  assign side_in.zero = 1'b0;
  assign side_in.r    = pix_i.in_red;
  assign side_in.g    = pix_i.in_green;
  assign side_in.b    = pix_i.in_blue;
  assign side_in.po   = point_op(mode_q, pix_i.in_red, pix_i.in_green, pix_i.in_blue);

  // distance to centre at or past full scale: vignette gives black
  assign zero = (CMP_W'(root) >= CMP_W'(full));

  always_comb begin
    side_c      = side_q[ST_C-1];
    side_c.zero = zero;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int i = 1; i < ST_OUT; i++) begin
        side_q[i] <= (i == ST_C) ? side_c : side_q[i-1];
      end
      // offsets from the centre
      dx_q <= $signed({1'b0, pix_i.pixel_col}) - $signed({1'b0, w_half});
      dy_q <= $signed({1'b0, pix_i.pixel_row}) - $signed({1'b0, h_half});
      // squared distance, offsets sign-extended to full product width
      d2_q <= $unsigned(D2_W'(dx_q) * D2_W'(dx_q)) +
              $unsigned(D2_W'(dy_q) * D2_W'(dy_q));
      // remaining scale
      n_q  <= zero ? '0 : FULL_W'(CMP_W'(full) - CMP_W'(root));
      prod_q[0] <= NUM_W'(side_q[ST_D-1].r) * NUM_W'(n_q);
      prod_q[1] <= NUM_W'(side_q[ST_D-1].g) * NUM_W'(n_q);
      prod_q[2] <= NUM_W'(side_q[ST_D-1].b) * NUM_W'(n_q);
      // select result
      if (side_q[ST_DV].vig) begin
        out_q <= side_q[ST_DV].zero ? '0 : {quo[0], quo[1], quo[2]};
      end else begin
        out_q <= side_q[ST_DV].po;
      end
    end
  end

  ppcf_sqrt_pipe #(
    .IN_W (RAD_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  ({d2_q, 16'h0000}),
    .root_o (root)
  );

  for (genvar ch = 0; ch < 3; ch++) begin : g_div
    ppcf_div_pipe #(
      .DEN_W (FULL_W),
      .Q_W   (CH_W),
      .NUM_W (NUM_W)
    ) u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  (prod_q[ch]),
      .den_i  (full),
      .quot_o (quo[ch])
    );
  end

  assign pix_o.valid     = vld_q[NST-1];
  assign pix_o.out_red   = out_q[3*CH_W-1 -: CH_W];
  assign pix_o.out_green = out_q[2*CH_W-1 -: CH_W];
  assign pix_o.out_blue  = out_q[CH_W-1:0];

endmodule

FILE: rtl/ppcf_sqrt_pipe.sv
// Pipelined integer square root, one root bit per register stage.
// Standalone; each register stage advances only while en_i is high.
`timescale 1ns / 1ps

module ppcf_sqrt_pipe #(
  parameter int unsigned IN_W = 42
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [IN_W-1:0]     rad_i,
  output logic [IN_W/2-1:0]   root_o
);

  localparam int unsigned R_W   = IN_W / 2;
  localparam int unsigned REM_W = R_W + 2;

  logic [REM_W-1:0] rem_q  [R_W];
  logic [R_W-1:0]   root_q [R_W];
  logic [IN_W-1:0]  rad_q  [R_W];

  for (genvar k = 0; k < R_W; k++) begin : g_st
    logic [REM_W-1:0] rem_p;
    logic [R_W-1:0]   root_p;
    logic [IN_W-1:0]  rad_p;
    logic [REM_W+1:0] cat;
    logic [REM_W-1:0] shr;
    logic [REM_W-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rad_p  = rad_q[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign cat   = {rem_p, rad_p[IN_W-1 -: 2]};
    assign shr   = cat[REM_W-1:0];
    assign trial = {root_p, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (shr >= trial) begin
          rem_q[k]  <= shr - trial;
          root_q[k] <= {root_p[R_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= shr;
          root_q[k] <= {root_p[R_W-2:0], 1'b0};
        end
        rad_q[k] <= {rad_p[IN_W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[R_W-1];

endmodule

FILE: rtl/ppcf_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; quotient must fit Q_W bits; each stage advances only while en_i is high.
`timescale 1ns / 1ps

module ppcf_div_pipe #(
  parameter int unsigned DEN_W = 21,
  parameter int unsigned Q_W   = 8,
  parameter int unsigned NUM_W = DEN_W + Q_W
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic [Q_W-1:0]    quot_o
);

  logic [NUM_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_st
    logic [NUM_W-1:0] rem_p;
    logic [Q_W-1:0]   quo_p;
    logic [NUM_W-1:0] dsh;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_p = num_i;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign quo_p = quo_q[k-1];
    end

    assign dsh  = NUM_W'(den_i) << (Q_W - 1 - k);
    assign take = (rem_p >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? (rem_p - dsh) : rem_p;
        quo_q[k] <= {quo_p[Q_W-2:0], take};
      end
    end
  end

  assign quot_o = quo_q[Q_W-1];

endmodule
